### hdl/ray_ground_point_classifier_core_defines.svh
// assertion macros for the ray ground point classifier
`ifndef RAY_GROUND_POINT_CLASSIFIER_CORE_DEFINES_SVH
`define RAY_GROUND_POINT_CLASSIFIER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define RGPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define RGPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RGPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define RGPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### hdl/rgpc_pkg.sv
// shared types and constants of the ray ground point classifier
package rgpc_pkg;

    localparam int HEIGHT_W = 16;
    localparam int RADIUS_W = 18;
    localparam int RATIO_W  = 16;
    localparam int FLOOR_W  = 15;
    localparam int TAG_W    = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [RATIO_W-1:0]  RST_LOCAL_SLOPE   = 16'd5734;
    localparam logic [RATIO_W-1:0]  RST_GENERAL_SLOPE = 16'd3435;
    localparam logic [RADIUS_W-1:0] RST_FLOOR_SPACING = 18'd0;
    localparam logic [FLOOR_W-1:0]  RST_HEIGHT_FLOOR  = 15'd50;
    localparam logic [RADIUS_W-1:0] RST_RECLASS_GAP   = 18'd200;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOCAL_SLOPE   = 3'd0,
        CFG_GENERAL_SLOPE = 3'd1,
        CFG_FLOOR_SPACING = 3'd2,
        CFG_HEIGHT_FLOOR  = 3'd3,
        CFG_RECLASS_GAP   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [RATIO_W-1:0]  loc_slope;
        logic [RATIO_W-1:0]  gen_slope;
        logic [RADIUS_W-1:0] floor_spacing;
        logic [FLOOR_W-1:0]  height_floor;
        logic [RADIUS_W-1:0] reclass_gap;
    } t_cfg;

    // classification flags of one point, waiting for the label recurrence
    typedef struct packed {
        logic             in_band;
        logic             cone_ok;
        logic             reclass_ok;
        logic             ray_start;
        logic [TAG_W-1:0] tag;
    } t_q_item;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

### hdl/rgpc_front.sv
// front end: accepts points, computes band and cone, derives the compare flags
module rgpc_front
    import rgpc_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cfg                       i_cfg,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [HEIGHT_W-1:0] i_point_height,
    input  logic [RADIUS_W-1:0]        i_point_radius,
    input  logic                       i_ray_start,
    input  logic [TAG_W-1:0]           i_point_tag,
    input  logic                       i_q_pop,
    output logic                       o_push,
    output t_q_item                    o_push_item
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] r_credit, n_credit;
    logic          accept;

    logic [RADIUS_W-1:0]        r_last_radius;
    logic signed [HEIGHT_W-1:0] r_last_height;

    // stage a
    logic                       r_a_valid;
    logic signed [RADIUS_W:0]   r_a_step;
    logic [RADIUS_W-1:0]        r_a_band_mag;
    logic [RADIUS_W-1:0]        r_a_cone;
    logic signed [HEIGHT_W-1:0] r_a_h;
    logic signed [HEIGHT_W-1:0] r_a_ph;
    logic                       r_a_start;
    logic [TAG_W-1:0]           r_a_tag;

    // stage b
    logic    r_b_valid;
    t_q_item r_b_item;

    logic [RADIUS_W-1:0]        pr;
    logic signed [HEIGHT_W-1:0] ph;
    logic signed [RADIUS_W:0]   step;
    logic [RADIUS_W-1:0]        step_mag;
    logic [33:0]                band_prod;
    logic [33:0]                cone_prod;

    logic signed [19:0] step20, band_pos, band0, band, fs20, hf20, rg20;
    logic signed [20:0] h21, ph21, band21, hi21, lo21, cone21;

    // outstanding points bound the queue fill
    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_credit == CW'(DEPTH));

    always_comb begin
        n_credit = r_credit;
        if (accept && !i_q_pop) begin
            n_credit = r_credit + CW'(1);
        end else if (!accept && i_q_pop) begin
            n_credit = r_credit - CW'(1);
        end
    end

    always_comb begin
        pr        = i_ray_start ? '0 : r_last_radius;
        ph        = i_ray_start ? '0 : r_last_height;
        step      = $signed({1'b0, i_point_radius}) - $signed({1'b0, pr});
        step_mag  = step[RADIUS_W] ? RADIUS_W'(-step) : step[RADIUS_W-1:0];
        band_prod = 34'(i_cfg.loc_slope) * 34'(step_mag);
        cone_prod = 34'(i_cfg.gen_slope) * 34'(i_point_radius);
    end

    always_comb begin
        step20   = 20'(r_a_step);
        band_pos = $signed({2'b00, r_a_band_mag});
        band0    = r_a_step[RADIUS_W] ? -band_pos : band_pos;
        fs20     = $signed({2'b00, i_cfg.floor_spacing});
        hf20     = $signed({5'b00000, i_cfg.height_floor});
        rg20     = $signed({2'b00, i_cfg.reclass_gap});
        // height floor when the radius step is large
        band     = (step20 > fs20 && band0 < hf20) ? hf20 : band0;
        h21      = 21'(r_a_h);
        ph21     = 21'(r_a_ph);
        band21   = 21'(band);
        hi21     = ph21 + band21;
        lo21     = ph21 - band21;
        cone21   = $signed({3'b000, r_a_cone});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit      <= '0;
            r_a_valid     <= 1'b0;
            r_b_valid     <= 1'b0;
            r_last_radius <= '0;
            r_last_height <= '0;
        end else begin
            r_credit  <= n_credit;
            r_a_valid <= accept;
            r_b_valid <= r_a_valid;
            if (accept) begin
                r_last_radius <= i_point_radius;
                r_last_height <= i_point_height;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_step     <= step;
        r_a_band_mag <= band_prod[33:16];
        r_a_cone     <= cone_prod[33:16];
        r_a_h        <= i_point_height;
        r_a_ph       <= ph;
        r_a_start    <= i_ray_start;
        r_a_tag      <= i_point_tag;

        r_b_item.in_band    <= (h21 <= hi21) && (h21 >= lo21);
        r_b_item.cone_ok    <= (h21 <= cone21) && (h21 >= -cone21);
        r_b_item.reclass_ok <= (step20 > rg20) && (h21 <= band21) && (h21 >= -band21);
        r_b_item.ray_start  <= r_a_start;
        r_b_item.tag        <= r_a_tag;
    end

    assign o_push      = r_b_valid;
    assign o_push_item = r_b_item;

endmodule

### hdl/rgpc_queue.sv
// short queue between front and back
module rgpc_queue
    import rgpc_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_q_item   i_item,
    input  logic      i_pop,
    output t_q_item   o_item,
    output t_q_status o_status
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_q_item       r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= wrap_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= wrap_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CW'(DEPTH));

endmodule

### hdl/rgpc_back.sv
// back end: resolves the ground label chain and holds the result register
module rgpc_back
    import rgpc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_q_item          i_q_item,
    output logic             o_q_pop,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output logic             o_is_ground,
    output logic [TAG_W-1:0] o_tag_out
);

    logic             r_out_valid;
    logic             r_is_ground;
    logic [TAG_W-1:0] r_tag;
    logic             r_last_ground;
    logic             prior_gnd;
    logic             ground;

    assign o_q_pop = i_q_valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        prior_gnd = i_q_item.ray_start ? 1'b0 : r_last_ground;
        ground    = i_q_item.in_band ? (prior_gnd || i_q_item.cone_ok)
                                     : i_q_item.reclass_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_last_ground <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_out_valid   <= 1'b1;
                r_last_ground <= ground;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_is_ground <= ground;
            r_tag       <= i_q_item.tag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_is_ground = r_is_ground;
    assign o_tag_out   = r_tag;

endmodule

### hdl/ray_ground_point_classifier_core.sv
// top level of the ray ground point classifier
//
// Points of one radial ray come in sorted by radius on the input channel
// (i_in_valid / o_in_stall), one point per request; i_ray_start marks the
// first point of a ray. Each point gives one result on the output channel
// (o_out_valid / i_out_stall): the ground label and the point's tag.
// An accepted point passes stage a, stage b and the queue to the output
// register, and the block takes one point every cycle while o_in_stall is
// low. The front computes band and cone products in one stage and the
// compares in the next; the back resolves the one-bit label chain as it
// pops the queue into the output register. A stalled result holds in the
// output register while the queue keeps taking points; o_in_stall rises once
// FIFO_DEPTH points are outstanding between the input and the output register.
// Configuration writes (i_cfg_valid / o_cfg_ready, always ready) load the
// slope, floor and gap registers; indexes past the list are dropped.
// Synchronous reset loads the default registers, empties the queue and
// clears the previous point to zero radius, zero height, not ground.
`include "ray_ground_point_classifier_core_defines.svh"
module ray_ground_point_classifier_core
    import rgpc_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [HEIGHT_W-1:0] i_point_height,
    input  logic [RADIUS_W-1:0]        i_point_radius,
    input  logic                       i_ray_start,
    input  logic [TAG_W-1:0]           i_point_tag,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_is_ground,
    output logic [TAG_W-1:0]           o_tag_out
);

    t_cfg      r_cfg;
    logic      q_push, q_pop;
    t_q_item   q_in_item, q_out_item;
    t_q_status q_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.loc_slope     <= RST_LOCAL_SLOPE;
            r_cfg.gen_slope     <= RST_GENERAL_SLOPE;
            r_cfg.floor_spacing <= RST_FLOOR_SPACING;
            r_cfg.height_floor  <= RST_HEIGHT_FLOOR;
            r_cfg.reclass_gap   <= RST_RECLASS_GAP;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LOCAL_SLOPE:   r_cfg.loc_slope     <= i_cfg_data[RATIO_W-1:0];
                CFG_GENERAL_SLOPE: r_cfg.gen_slope     <= i_cfg_data[RATIO_W-1:0];
                CFG_FLOOR_SPACING: r_cfg.floor_spacing <= i_cfg_data[RADIUS_W-1:0];
                CFG_HEIGHT_FLOOR:  r_cfg.height_floor  <= i_cfg_data[FLOOR_W-1:0];
                CFG_RECLASS_GAP:   r_cfg.reclass_gap   <= i_cfg_data[RADIUS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    rgpc_front #(
        .DEPTH(FIFO_DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_point_height (i_point_height),
        .i_point_radius (i_point_radius),
        .i_ray_start    (i_ray_start),
        .i_point_tag    (i_point_tag),
        .i_q_pop        (q_pop),
        .o_push         (q_push),
        .o_push_item    (q_in_item)
    );

    rgpc_queue #(
        .DEPTH(FIFO_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_item   (q_in_item),
        .i_pop    (q_pop),
        .o_item   (q_out_item),
        .o_status (q_stat)
    );

    rgpc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (!q_stat.empty),
        .i_q_item    (q_out_item),
        .o_q_pop     (q_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_is_ground (o_is_ground),
        .o_tag_out   (o_tag_out)
    );

    // credit accounting must keep the queue from overflowing
    `RGPC_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, q_push, !q_stat.full || q_pop, "queue push while full")
    `RGPC_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, q_pop, !q_stat.empty, "queue pop while empty")
    `RGPC_ASSERT_NXT(a_refill, i_clk, i_rst_n, o_out_valid && !i_out_stall && !q_stat.empty, o_out_valid, "output bubble with queue not empty")

endmodule
